// ===== rtl/core/http_header_field_parser_assert.svh =====
// Assertion macros used by the checker of the header parser.
// Depends on nothing; include by bare file name.
`ifndef HTTP_HEADER_FIELD_PARSER_ASSERT_SVH
`define HTTP_HEADER_FIELD_PARSER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HHFP_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("header parser check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define HHFP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("header parser check failed");

`endif

// ===== rtl/core/hhfp_pkg.sv =====
// Shared types, codes and character helpers of the HTTP header field parser.
// No dependencies; compile first after the assertion header.
`timescale 1ns / 1ps

package hhfp_pkg;

  localparam int unsigned MAX_HDR_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HEADER_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POST_METHOD      = 2'd1;

  localparam logic [MAX_HDR_W-1:0] MAX_HDR_RESET = 16'd8192;

  // Error codes
  localparam logic [1:0] ERR_NONE = 2'd0;  // no error
  localparam logic [1:0] ERR_BAD  = 2'd1;  // 400 bad request
  localparam logic [1:0] ERR_BIG  = 2'd2;  // 431 header too large

  // Byte classes
  localparam logic [1:0] CLS_SYNTAX = 2'd0;
  localparam logic [1:0] CLS_NAME   = 2'd1;
  localparam logic [1:0] CLS_VALUE  = 2'd2;

  // Characters with a role in the syntax
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VTAB   = 8'h0B;
  localparam logic [7:0] CH_FFEED  = 8'h0C;

  typedef struct packed {
    logic [MAX_HDR_W-1:0] max_header_bytes;
    logic                 post_method;
  } hhfp_cfg_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic [1:0] byte_class;
    logic       name_done;
    logic       field_done;
    logic       headers_done;
    logic       body_follows;
    logic [1:0] error_code;
  } hhfp_result_t;

  function automatic logic is_name_byte(input logic [7:0] c);
    logic lower, upper, digit;
    lower = (c >= 8'h61) && (c <= 8'h7A);
    upper = (c >= 8'h41) && (c <= 8'h5A);
    digit = (c >= 8'h30) && (c <= 8'h39);
    return lower || upper || digit || (c == CH_DASH) || (c == CH_UNDER);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_FFEED) || (c == CH_VTAB);
  endfunction

endpackage

// ===== rtl/core/hhfp_if.sv =====
// Stream interfaces of the header parser: byte input, tagged output, config writes.
// Depends on hhfp_pkg.
`timescale 1ns / 1ps

interface hhfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_section;

  modport source (output valid, output data_byte, output new_section, input ready);
  modport sink   (input valid, input data_byte, input new_section, output ready);
endinterface

interface hhfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic [1:0] byte_class;
  logic       name_done;
  logic       field_done;
  logic       headers_done;
  logic       body_follows;
  logic [1:0] error_code;

  modport source (output valid, output data_out, output byte_class, output name_done,
                  output field_done, output headers_done, output body_follows,
                  output error_code, input ready);
  modport sink   (input valid, input data_out, input byte_class, input name_done,
                  input field_done, input headers_done, input body_follows,
                  input error_code, output ready);
endinterface

interface hhfp_cfg_if;
  import hhfp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [MAX_HDR_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/hhfp_core.sv =====
// Parse state machine, byte counter, sticky error and result register.
// Depends on hhfp_pkg.
`timescale 1ns / 1ps

module hhfp_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 new_section_i,
  input  hhfp_pkg::hhfp_cfg_t  cfg_i,
  output hhfp_pkg::hhfp_result_t res_o
);
  import hhfp_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > MAX_HDR_W) ? COUNT_WIDTH : MAX_HDR_W;

  typedef enum logic [2:0] {
    ST_LINE, ST_EMPTY_CR, ST_NAME, ST_LEAD, ST_VALUE, ST_NEED_LF, ST_DONE
  } state_e;

  state_e                 state_q, state_d, st_cur;
  logic [COUNT_WIDTH-1:0] count_q, count_d, count_cur, count_inc;
  logic [1:0]             err_q, err_d, err_cur;
  hhfp_result_t           res_q, res_d;
  logic                   bad, counted;

  always_comb begin
    st_cur    = new_section_i ? ST_LINE : state_q;
    count_cur = new_section_i ? '0 : count_q;
    err_cur   = new_section_i ? ERR_NONE : err_q;
    count_inc = count_cur + COUNT_WIDTH'(~&count_cur);

    state_d = st_cur;
    count_d = count_cur;
    err_d   = err_cur;
    bad     = 1'b0;
    counted = 1'b1;
    res_d   = '0;
    res_d.data_out = data_byte_i;

    if ((err_cur == ERR_NONE) && (st_cur != ST_DONE)) begin
      unique case (st_cur)
        ST_LINE: begin
          if (data_byte_i == CH_CR) begin
            state_d = ST_EMPTY_CR;
          end else if (data_byte_i == CH_LF) begin
            res_d.headers_done = 1'b1;
            res_d.body_follows = cfg_i.post_method;
            state_d = ST_DONE;
            counted = 1'b0;
          end else if (data_byte_i == CH_COLON) begin
            res_d.name_done = 1'b1;
            state_d = ST_LEAD;
          end else if (is_name_byte(data_byte_i)) begin
            res_d.byte_class = CLS_NAME;
            state_d = ST_NAME;
          end else begin
            bad = 1'b1;
          end
        end
        ST_EMPTY_CR: begin
          if (data_byte_i == CH_LF) begin
            res_d.headers_done = 1'b1;
            res_d.body_follows = cfg_i.post_method;
            state_d = ST_DONE;
            counted = 1'b0;
          end else begin
            bad = 1'b1;
          end
        end
        ST_NAME: begin
          if (data_byte_i == CH_COLON) begin
            res_d.name_done = 1'b1;
            state_d = ST_LEAD;
          end else if (is_name_byte(data_byte_i)) begin
            res_d.byte_class = CLS_NAME;
          end else begin
            bad = 1'b1;
          end
        end
        ST_LEAD, ST_VALUE: begin
          if (data_byte_i == CH_CR) begin
            res_d.field_done = 1'b1;
            state_d = ST_NEED_LF;
          end else if (data_byte_i == CH_LF) begin
            res_d.field_done = 1'b1;
            state_d = ST_LINE;
          end else if ((st_cur == ST_LEAD) && is_blank(data_byte_i)) begin
            res_d.byte_class = CLS_SYNTAX;
          end else begin
            res_d.byte_class = CLS_VALUE;
            state_d = ST_VALUE;
          end
        end
        ST_NEED_LF: begin
          if (data_byte_i == CH_LF) begin
            state_d = ST_LINE;
          end else begin
            bad = 1'b1;
          end
        end
        default: begin
          state_d = ST_LINE;
          bad = 1'b1;
        end
      endcase

      if (bad) begin
        err_d = ERR_BAD;
      end else if (counted) begin
        count_d = count_inc;
        if (CMP_W'(count_inc) > CMP_W'(cfg_i.max_header_bytes)) begin
          err_d = ERR_BIG;
        end
      end
      if (err_d != ERR_NONE) begin
        res_d.byte_class   = CLS_SYNTAX;
        res_d.name_done    = 1'b0;
        res_d.field_done   = 1'b0;
        res_d.headers_done = 1'b0;
        res_d.body_follows = 1'b0;
      end
    end
    res_d.error_code = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LINE;
      count_q <= '0;
      err_q   <= ERR_NONE;
    end else if (step_i) begin
      state_q <= state_d;
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/core/http_header_field_parser.sv =====
// Top level of the HTTP header field parser: handshakes, config registers, input stage.
// Depends on hhfp_pkg, hhfp_if and hhfp_core.
`timescale 1ns / 1ps
//
//   channel  | dir | payload                                   | transfer when
//   ---------+-----+-------------------------------------------+------------------
//   byte_i   | in  | data_byte, new_section                    | valid && ready
//   tag_o    | out | data_out, byte_class, *_done, body_follows,| valid && ready
//            |     | error_code                                |
//   cfg_i    | in  | index, wdata                              | valid && ready
//
// One byte per cycle sustained while tag_o takes each result. A byte passes through
// the input and result registers to tag_o; the next parse state is combinational.
// Reset clears the parse state, byte count, error and both valid flags, and
// loads the register reset values. A stall on tag_o holds the result and the
// input register; byte_i stays ready while the input register is empty.
// cfg_i is always ready; write it only while the parser is idle.

module http_header_field_parser #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hhfp_in_if.sink    byte_i,
  hhfp_out_if.source tag_o,
  hhfp_cfg_if.sink   cfg_i
);
  import hhfp_pkg::*;

  hhfp_cfg_t    cfg_q;
  logic         in_valid_q, out_valid_q;
  logic [7:0]   byte_q;
  logic         fresh_q;
  logic         advance, step, in_xfer;
  hhfp_result_t res;

  // The result register frees up when it is empty or being taken.
  assign advance = !out_valid_q || tag_o.ready;
  assign step    = in_valid_q && advance;

  assign byte_i.ready = !in_valid_q || advance;
  assign in_xfer      = byte_i.valid && byte_i.ready;
  assign cfg_i.ready  = 1'b1;

  // Configuration registers; unknown indexes drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_header_bytes <= MAX_HDR_RESET;
      cfg_q.post_method      <= 1'b0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_MAX_HEADER_BYTES) begin
        cfg_q.max_header_bytes <= cfg_i.wdata;
      end else if (cfg_i.index == REG_POST_METHOD) begin
        cfg_q.post_method <= cfg_i.wdata[0];
      end
    end
  end

  // Valid flags of the input and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (byte_i.ready) begin
        in_valid_q <= byte_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Input payload register: load on every transfer.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q  <= byte_i.data_byte;
      fresh_q <= byte_i.new_section;
    end
  end

  hhfp_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .data_byte_i   (byte_q),
    .new_section_i (fresh_q),
    .cfg_i         (cfg_q),
    .res_o         (res)
  );

  assign tag_o.valid        = out_valid_q;
  assign tag_o.data_out     = res.data_out;
  assign tag_o.byte_class   = res.byte_class;
  assign tag_o.name_done    = res.name_done;
  assign tag_o.field_done   = res.field_done;
  assign tag_o.headers_done = res.headers_done;
  assign tag_o.body_follows = res.body_follows;
  assign tag_o.error_code   = res.error_code;

endmodule

// ===== rtl/core/hhfp_checker.sv =====
// Port-level checks of the header parser's result stream, bound to the top level.
// Depends on hhfp_pkg and http_header_field_parser_assert.svh.
`timescale 1ns / 1ps
`include "http_header_field_parser_assert.svh"

module hhfp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_i,
  input logic [7:0] data_out_i,
  input logic [1:0] byte_class_i,
  input logic       name_done_i,
  input logic       field_done_i,
  input logic       headers_done_i,
  input logic       body_follows_i,
  input logic [1:0] error_code_i
);
  import hhfp_pkg::*;

  logic        has_err;
  logic        tag_quiet;
  logic        hdr_alone;
  logic [15:0] tag_bits;

  assign has_err   = (error_code_i != ERR_NONE);
  assign tag_quiet = (byte_class_i == CLS_SYNTAX) && !name_done_i && !field_done_i &&
                     !headers_done_i && !body_follows_i;
  assign hdr_alone = (byte_class_i == CLS_SYNTAX) && !name_done_i && !field_done_i &&
                     !has_err;
  assign tag_bits  = {data_out_i, byte_class_i, name_done_i, field_done_i,
                      headers_done_i, body_follows_i, error_code_i};

  // A byte flagged with an error carries no class and no flags.
  `HHFP_ASSERT_NOW(a_err_quiet, clk_i, rst_ni, valid_i && has_err, tag_quiet)

  // The section end is a syntax byte without name or field flags or an error.
  `HHFP_ASSERT_NOW(a_hdr_done_alone, clk_i, rst_ni, valid_i && headers_done_i, hdr_alone)

  // Body indication only rides on the section end.
  `HHFP_ASSERT_NOW(a_body_with_done, clk_i, rst_ni, valid_i && body_follows_i, headers_done_i)

  // A stalled result holds still.
  `HHFP_ASSERT_NEXT(a_hold_stall, clk_i, rst_ni, valid_i && !ready_i, valid_i && $stable(tag_bits))

endmodule

bind http_header_field_parser hhfp_checker u_hhfp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_i        (tag_o.valid),
  .ready_i        (tag_o.ready),
  .data_out_i     (tag_o.data_out),
  .byte_class_i   (tag_o.byte_class),
  .name_done_i    (tag_o.name_done),
  .field_done_i   (tag_o.field_done),
  .headers_done_i (tag_o.headers_done),
  .body_follows_i (tag_o.body_follows),
  .error_code_i   (tag_o.error_code)
);

// ===== tb/testbench.sv =====
// Self-checking bench for http_header_field_parser: directed rows, random header sections,
// and a closing long value line, checked against an in-bench tag predictor or pinned tags.
// Depends on hhfp_pkg, hhfp_if and the parser RTL.
`timescale 1ns / 1ps

module testbench;
  import hhfp_pkg::*;

  localparam int unsigned COUNT_W     = 16;
  localparam int          CYCLE_LIMIT = 800000;
  localparam int          PHASE_BYTES = 235;    // minimum bytes sent per random phase
  localparam int          LONG_LEN    = 60;     // value bytes of the closing long line
  localparam int          DIR_ROWS    = 26;
  localparam int          CFG_SWAP_ROW = 18;    // directed rows from here run at limit 1, POST

  // Indexes that map to no register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Done flags as {name_done, field_done, headers_done, body_follows}
  localparam logic [3:0] F_NONE     = 4'b0000;
  localparam logic [3:0] F_NAME     = 4'b1000;
  localparam logic [3:0] F_FIELD    = 4'b0100;
  localparam logic [3:0] F_HDR      = 4'b0010;
  localparam logic [3:0] F_HDR_BODY = 4'b0011;

  typedef enum logic [2:0] {
    PS_LINE, PS_EMPTY_CR, PS_NAME, PS_LEAD, PS_VALUE, PS_NEED_LF, PS_DONE
  } parse_st_e;

  typedef struct packed {
    logic [7:0] c;
    logic       fresh;
    logic       pinned;  // expected tag typed in below rather than predicted
    logic [1:0] cls;
    logic [3:0] flags;
    logic [1:0] err;
  } dir_row_t;

  logic clk;
  logic rst_n;

  hhfp_in_if  byte_ch ();
  hhfp_out_if tag_ch ();
  hhfp_cfg_if cfg_ch ();

  http_header_field_parser dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .byte_i (byte_ch),
    .tag_o  (tag_ch),
    .cfg_i  (cfg_ch)
  );

  // Predictor state: register copies and the parse state of the section.
  logic [MAX_HDR_W-1:0] limit_bytes;
  logic                 post_flag;
  parse_st_e            pstate;
  logic [COUNT_W-1:0]   hdr_count;
  logic [1:0]           hdr_err;
  bit                   last_live;

  hhfp_result_t pending_tags [$];
  int  mismatches;
  int  tags_checked;
  int  sent_bytes;
  int  cycles;
  bit  calm;           // no idling on either side
  bit  noisy;          // garble some well-formed bytes
  bit  pressure_done;

  // Directed rows. Reset config for the first part: limit 8192, no body.
  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{"H",       1'b1, 1'b1, CLS_NAME,   F_NONE,     ERR_NONE},
    '{"-",       1'b0, 1'b0, CLS_SYNTAX, F_NONE,     ERR_NONE},
    '{CH_COLON,  1'b0, 1'b1, CLS_SYNTAX, F_NAME,     ERR_NONE},
    '{CH_SPACE,  1'b0, 1'b0, CLS_SYNTAX, F_NONE,     ERR_NONE},  // leading blank skipped
    '{8'hFF,     1'b0, 1'b1, CLS_VALUE,  F_NONE,     ERR_NONE},
    '{CH_CR,     1'b0, 1'b0, CLS_SYNTAX, F_NONE,     ERR_NONE},
    '{CH_LF,     1'b0, 1'b0, CLS_SYNTAX, F_NONE,     ERR_NONE},
    '{CH_COLON,  1'b0, 1'b0, CLS_SYNTAX, F_NONE,     ERR_NONE},  // empty name
    '{CH_TAB,    1'b0, 1'b0, CLS_SYNTAX, F_NONE,     ERR_NONE},
    '{8'h00,     1'b0, 1'b1, CLS_VALUE,  F_NONE,     ERR_NONE},
    '{CH_LF,     1'b0, 1'b1, CLS_SYNTAX, F_FIELD,    ERR_NONE},  // bare LF ends value
    '{CH_CR,     1'b0, 1'b0, CLS_SYNTAX, F_NONE,     ERR_NONE},
    '{CH_LF,     1'b0, 1'b1, CLS_SYNTAX, F_HDR,      ERR_NONE},
    '{"x",       1'b0, 1'b0, CLS_SYNTAX, F_NONE,     ERR_NONE},  // past end of section
    '{"A",       1'b1, 1'b0, CLS_SYNTAX, F_NONE,     ERR_NONE},
    '{CH_SPACE,  1'b0, 1'b1, CLS_SYNTAX, F_NONE,     ERR_BAD},   // blank inside a name
    '{"B",       1'b0, 1'b1, CLS_SYNTAX, F_NONE,     ERR_BAD},   // error held
    '{CH_LF,     1'b1, 1'b1, CLS_SYNTAX, F_HDR,      ERR_NONE},  // empty section
    '{"a",       1'b1, 1'b0, CLS_SYNTAX, F_NONE,     ERR_NONE},
    '{CH_COLON,  1'b0, 1'b1, CLS_SYNTAX, F_NONE,     ERR_BIG},   // second byte over limit 1
    '{CH_LF,     1'b1, 1'b1, CLS_SYNTAX, F_HDR_BODY, ERR_NONE},
    '{"k",       1'b1, 1'b0, CLS_SYNTAX, F_NONE,     ERR_NONE},
    '{"@",       1'b0, 1'b1, CLS_SYNTAX, F_NONE,     ERR_BAD},   // bad and too big: 400 wins
    '{CH_CR,     1'b1, 1'b0, CLS_SYNTAX, F_NONE,     ERR_NONE},
    '{CH_CR,     1'b0, 1'b1, CLS_SYNTAX, F_NONE,     ERR_BAD},   // empty-line CR without LF
    '{"_",       1'b1, 1'b1, CLS_NAME,   F_NONE,     ERR_NONE}
  };

  function automatic bit name_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == CH_DASH || c == CH_UNDER;
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_FFEED || c == CH_VTAB;
  endfunction

  // Advance the predictor by one byte and return the tag it should get.
  function automatic hhfp_result_t tag_byte(input logic [7:0] c, input logic fresh);
    hhfp_result_t r;
    bit bad;
    bit counted;
    r = '0;
    r.data_out = c;
    bad = 1'b0;
    counted = 1'b1;
    if (fresh) begin
      hdr_count = '0;
      hdr_err   = ERR_NONE;
      pstate    = PS_LINE;
    end
    last_live = (hdr_err == ERR_NONE) && (pstate != PS_DONE);
    if (last_live) begin
      case (pstate)
        PS_LINE: begin
          if (c == CH_CR) begin
            pstate = PS_EMPTY_CR;
          end else if (c == CH_LF) begin
            r.headers_done = 1'b1;
            r.body_follows = post_flag;
            pstate = PS_DONE;
            counted = 1'b0;
          end else if (c == CH_COLON) begin
            r.name_done = 1'b1;
            pstate = PS_LEAD;
          end else if (name_char(c)) begin
            r.byte_class = CLS_NAME;
            pstate = PS_NAME;
          end else begin
            bad = 1'b1;
          end
        end
        PS_EMPTY_CR: begin
          if (c == CH_LF) begin
            r.headers_done = 1'b1;
            r.body_follows = post_flag;
            pstate = PS_DONE;
            counted = 1'b0;
          end else begin
            bad = 1'b1;
          end
        end
        PS_NAME: begin
          if (c == CH_COLON) begin
            r.name_done = 1'b1;
            pstate = PS_LEAD;
          end else if (name_char(c)) begin
            r.byte_class = CLS_NAME;
          end else begin
            bad = 1'b1;
          end
        end
        PS_LEAD, PS_VALUE: begin
          if (c == CH_CR) begin
            r.field_done = 1'b1;
            pstate = PS_NEED_LF;
          end else if (c == CH_LF) begin
            r.field_done = 1'b1;
            pstate = PS_LINE;
          end else if (!(pstate == PS_LEAD && blank_char(c))) begin
            r.byte_class = CLS_VALUE;
            pstate = PS_VALUE;
          end
        end
        PS_NEED_LF: begin
          if (c == CH_LF) pstate = PS_LINE;
          else bad = 1'b1;
        end
        default: begin
          pstate = PS_LINE;
          bad = 1'b1;
        end
      endcase
      if (bad) begin
        hdr_err = ERR_BAD;
      end else if (counted) begin
        if (hdr_count != '1) hdr_count = hdr_count + 1'b1;
        if (hdr_count > limit_bytes) hdr_err = ERR_BIG;
      end
      if (hdr_err != ERR_NONE) begin
        r.byte_class   = CLS_SYNTAX;
        r.name_done    = 1'b0;
        r.field_done   = 1'b0;
        r.headers_done = 1'b0;
        r.body_follows = 1'b0;
      end
    end
    r.error_code = hdr_err;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    $display("tag %0d: %s got %0h want %0h", tags_checked, what, got, want);
  endtask

  // Offer one byte from a falling edge, hold it until the transfer, and
  // record its expected tag at that edge. Returns at the next falling edge.
  task automatic send_byte(input logic [7:0] c, input logic fresh, input bit pinned,
                           input hhfp_result_t pin);
    hhfp_result_t guess;
    if (!calm && $urandom_range(0, 3) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.data_byte   <= c;
    byte_ch.new_section <= fresh;
    do @(posedge clk); while (!byte_ch.ready);
    guess = tag_byte(c, fresh);
    sent_bytes++;
    pending_tags.push_back(pinned ? pin : guess);
    @(negedge clk);
  endtask

  // Send a byte, now and then replacing it or marking a stray section start.
  task automatic put_byte(input logic [7:0] c, input logic fresh);
    logic [7:0] b;
    logic       f;
    b = c;
    f = fresh;
    if (noisy && $urandom_range(0, 59) == 0) b = 8'($urandom_range(0, 255));
    if (noisy && $urandom_range(0, 199) == 0) f = 1'b1;
    send_byte(b, f, 1'b0, '0);
  endtask

  function automatic logic [7:0] value_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] pick_name_char();
    int r;
    r = $urandom_range(0, 63);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return (r == 62) ? CH_DASH : CH_UNDER;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_FFEED;
      default: return CH_VTAB;
    endcase
  endfunction

  // One header section: a few fields with random content, each ended by
  // CRLF or a bare LF, then the empty line; sometimes stray bytes after.
  task automatic send_section();
    int nfields;
    int len;
    bit first;
    first = 1'b1;
    nfields = $urandom_range(0, 5);
    repeat (nfields) begin
      len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      repeat (len) begin
        put_byte(pick_name_char(), first);
        first = 1'b0;
      end
      put_byte(CH_COLON, first);
      first = 1'b0;
      repeat ($urandom_range(0, 2)) put_byte(pick_blank(), 1'b0);
      repeat ($urandom_range(0, 12)) put_byte(value_byte(), 1'b0);
      if ($urandom_range(0, 2) != 0) put_byte(CH_CR, 1'b0);
      put_byte(CH_LF, 1'b0);
    end
    if ($urandom_range(0, 2) != 0) begin
      put_byte(CH_CR, first);
      first = 1'b0;
    end
    put_byte(CH_LF, first);
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAX_HDR_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_MAX_HEADER_BYTES) limit_bytes = val;
    else if (idx == REG_POST_METHOD) post_flag = val[0];
    @(negedge clk);
  endtask

  // Stop offering bytes and wait for every expected tag to come back.
  task automatic drain_tags();
    byte_ch.valid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Rewrite both registers while the parser is idle; the upper wdata bits
  // of the one-bit register are random and must be dropped.
  task automatic reconfigure(input logic [MAX_HDR_W-1:0] max_bytes, input logic post,
                             input bit with_spares);
    logic [MAX_HDR_W-1:0] junk;
    drain_tags();
    junk = MAX_HDR_W'($urandom);
    write_reg(REG_MAX_HEADER_BYTES, max_bytes);
    write_reg(REG_POST_METHOD, {junk[MAX_HDR_W-1:1], post});
    if (with_spares) begin
      write_reg(REG_SPARE_A, MAX_HDR_W'($urandom));
      write_reg(REG_SPARE_B, MAX_HDR_W'($urandom));
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.new_section = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Receiver side: random stall bursts, plus one long hold-off so the
  // parser fills up and has to drop byte_i.ready.
  initial begin
    tag_ch.ready = 1'b0;
    pressure_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!pressure_done && tags_checked >= 500) begin
        pressure_done = 1'b1;
        tag_ch.ready <= 1'b0;
        repeat (64) @(negedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        tag_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        tag_ch.ready <= 1'b1;
      end
    end
  end

  // Compare every tag transfer with the oldest expectation.
  always @(posedge clk) begin
    hhfp_result_t want;
    if (rst_n && tag_ch.valid && tag_ch.ready) begin
      if (pending_tags.size() == 0) begin
        report_mismatch("tag with nothing pending, data_out", tag_ch.data_out, 8'h00);
      end else begin
        want = pending_tags.pop_front();
        if (tag_ch.data_out !== want.data_out)
          report_mismatch("data_out", tag_ch.data_out, want.data_out);
        if (tag_ch.byte_class !== want.byte_class)
          report_mismatch("byte_class", 8'(tag_ch.byte_class), 8'(want.byte_class));
        if (tag_ch.name_done !== want.name_done)
          report_mismatch("name_done", 8'(tag_ch.name_done), 8'(want.name_done));
        if (tag_ch.field_done !== want.field_done)
          report_mismatch("field_done", 8'(tag_ch.field_done), 8'(want.field_done));
        if (tag_ch.headers_done !== want.headers_done)
          report_mismatch("headers_done", 8'(tag_ch.headers_done), 8'(want.headers_done));
        if (tag_ch.body_follows !== want.body_follows)
          report_mismatch("body_follows", 8'(tag_ch.body_follows), 8'(want.body_follows));
        if (tag_ch.error_code !== want.error_code)
          report_mismatch("error_code", 8'(tag_ch.error_code), 8'(want.error_code));
      end
      tags_checked++;
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Main sequence
  initial begin
    int ph_max [0:6];
    int ph_post [0:6];
    int phase_start;
    hhfp_result_t want;

    ph_max  = '{1, 2, 40, 65535, 200, 0, 16};
    ph_post = '{1, 0, 1, 0, 1, 0, 0};
    limit_bytes = MAX_HDR_RESET;
    post_flag   = 1'b0;
    pstate      = PS_LINE;
    hdr_count   = '0;
    hdr_err     = ERR_NONE;
    mismatches = 0;
    tags_checked = 0;
    sent_bytes = 0;
    cycles = 0;
    calm = 1'b0;
    noisy = 1'b0;

    @(posedge rst_n);
    @(negedge clk);

    // Directed rows: reset config first, then limit 1 with a body expected.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == CFG_SWAP_ROW) reconfigure(16'd1, 1'b1, 1'b1);
      want = {dir_rows[i].c, dir_rows[i].cls, dir_rows[i].flags, dir_rows[i].err};
      send_byte(dir_rows[i].c, dir_rows[i].fresh, dir_rows[i].pinned, want);
    end

    // Random sections over a spread of limits; one phase draws its own.
    ph_max[5] = $urandom_range(1, 150);
    ph_post[5] = $urandom_range(0, 1);
    for (int p = 0; p < 7; p++) begin
      reconfigure(MAX_HDR_W'(ph_max[p]), ph_post[p][0], 1'b0);
      calm = ($urandom_range(0, 3) == 0);
      noisy = 1'b1;
      phase_start = sent_bytes;
      while (sent_bytes - phase_start < PHASE_BYTES) send_section();
    end

    // Last part, no idling: one long value line at the top limit, which
    // must never flag too-large.
    calm = 1'b1;
    noisy = 1'b0;
    reconfigure(16'hFFFF, 1'b1, 1'b0);
    put_byte("X", 1'b1);
    put_byte(CH_COLON, 1'b0);
    repeat (LONG_LEN) put_byte(value_byte(), 1'b0);
    put_byte(CH_CR, 1'b0);
    put_byte(CH_LF, 1'b0);
    put_byte(CH_LF, 1'b0);

    drain_tags();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
